@@ sv/ffha_pkg.sv @@
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

   // arena geometry
   localparam int GRANULE_BYTES = 8;
   localparam int GRAN_SHIFT    = 3;
   localparam int HEADER_BYTES  = 16;
   localparam int HDR_GR        = (HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
   localparam int HDR_SPAN      = HDR_GR * GRANULE_BYTES;

   // request and response field widths
   localparam int BYTES_W = 16;
   localparam int ADDR_W  = 15;
   localparam int SZ_W    = 14;
   localparam int HP_W    = 12;

   // request command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // response status codes
   typedef enum logic [2:0] {
      RES_ALLOC   = 3'd0,
      RES_ZERO    = 3'd1,
      RES_NOSPACE = 3'd2,
      RES_FREED   = 3'd3,
      RES_IGNORED = 3'd4
   } result_type;

   // controller states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_INIT,
      ST_A_RD,
      ST_A_CHK,
      ST_A_WR,
      ST_A_SPLIT,
      ST_F_RD,
      ST_F_CHK,
      ST_F_NX,
      ST_F_NXC,
      ST_F_PV,
      ST_F_PVC,
      ST_F_MERGE,
      ST_SB_RD,
      ST_SB_WR,
      ST_DONE
   } state_type;

   // datapath operations
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LATCH,
      OP_INIT,
      OP_POS_ZERO,
      OP_RD_POS,
      OP_STEP,
      OP_A_WR,
      OP_A_SPLIT,
      OP_RD_NEXT,
      OP_CAP_NEXT,
      OP_RD_PREV,
      OP_CAP_PREV,
      OP_MERGE,
      OP_RD_SB,
      OP_WR_SB,
      OP_LOAD_RSP
   } op_type;

   typedef struct packed {
      op_type     op;
      result_type code;
   } cmd_type;

   typedef struct packed {
      logic is_free_cmd;
      logic zero_size;
      logic free_bad;
      logic started;
      logic past_last;
      logic fit;
      logic split;
      logic at_target;
      logic beyond_target;
      logic target_free;
      logic pfree;
      logic nfree;
      logic sb_hpos;
      logic sb_np;
   } stat_type;

endpackage

@@ sv/ffha_req_if.sv @@
// ----------------------------------------------------------------------------
// ffha_req_if
// Request channel: command, requested size and address to free.
// ----------------------------------------------------------------------------
interface ffha_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [15:0] req_bytes;
   logic [14:0] block_addr;

   modport source (output valid, cmd, req_bytes, block_addr, input ready);
   modport sink   (input valid, cmd, req_bytes, block_addr, output ready);
endinterface

@@ sv/ffha_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ffha_rsp_if
// Response channel: payload offset and status.
// ----------------------------------------------------------------------------
interface ffha_rsp_if;
   logic        valid;
   logic        ready;
   logic [14:0] payload_addr;
   logic [2:0]  status;

   modport source (output valid, payload_addr, status, input ready);
   modport sink   (input valid, payload_addr, status, output ready);
endinterface

@@ sv/ffha_dpath.sv @@
// ----------------------------------------------------------------------------
// ffha_dpath
// Header memory, walk position, captured headers and response registers.
// ----------------------------------------------------------------------------
module ffha_dpath #(
   parameter int ARENA_GRANULES = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ffha_pkg::cmd_type            cmd,
   output ffha_pkg::stat_type           stat,
   input  logic                         req_cmd,
   input  logic [ffha_pkg::BYTES_W-1:0] req_bytes,
   input  logic [ffha_pkg::ADDR_W-1:0]  req_block_addr,
   output logic [ffha_pkg::ADDR_W-1:0]  rsp_payload_addr,
   output logic [2:0]                   rsp_status
);

   localparam int AW = $clog2(ARENA_GRANULES);
   localparam int CW = $clog2(ARENA_GRANULES + 1);
   localparam int XW = ((CW > ffha_pkg::SZ_W) ? CW : ffha_pkg::SZ_W) + 1;
   localparam logic [CW-1:0] ARENA  = CW'(ARENA_GRANULES);
   localparam logic [CW-1:0] HDR    = CW'(ffha_pkg::HDR_GR);

   typedef struct packed {
      logic [CW-1:0] size;
      logic [AW-1:0] back;
      logic          free;
      logic          has_back;
   } hdr_type;

   // header memory
   hdr_type mem [ARENA_GRANULES];
   hdr_type rdata_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   hdr_type       wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   // request and walk registers
   logic                        cmd_ff;
   logic [ffha_pkg::SZ_W-1:0]   sz_ff, sz_in;
   logic [ffha_pkg::ADDR_W-1:0] addr_ff;
   logic [CW-1:0]               pos_ff, pos_in;
   logic [CW-1:0]               hpos_ff;
   hdr_type                     hcur_ff, nb_ff, pb_ff;
   logic                        nfree_ff, pfree_ff;
   logic [CW-1:0]               last_ff, last_in;
   logic                        started_ff, started_in;
   logic [CW-1:0]               sb_pos_ff, sb_pos_in;
   logic [AW-1:0]               sb_val_ff, sb_val_in;
   logic [ffha_pkg::ADDR_W-1:0] rsp_addr_ff;
   logic [2:0]                  rsp_status_ff;

   // derived positions and sizes
   logic [ffha_pkg::HP_W-1:0]   hp;
   logic [CW-1:0]               succ_pos, np, np_succ, np_split;
   logic [AW-1:0]               pp;
   logic [CW+2:0]               pay_full;

   always_comb begin
      sz_in    = ffha_pkg::SZ_W'((17'(req_bytes) + 17'(ffha_pkg::GRANULE_BYTES - 1))
                 >> ffha_pkg::GRAN_SHIFT);
      hp       = ffha_pkg::HP_W'((addr_ff - ffha_pkg::ADDR_W'(ffha_pkg::HDR_SPAN))
                 >> ffha_pkg::GRAN_SHIFT);
      succ_pos = pos_ff + HDR + rdata_ff.size;
      np       = hpos_ff + HDR + hcur_ff.size;
      np_succ  = np + HDR + nb_ff.size;
      np_split = hpos_ff + HDR + CW'(sz_ff);
      pp       = hcur_ff.back;
      pay_full = {hpos_ff, 3'b000} + (CW+3)'(ffha_pkg::HDR_SPAN);
   end

   // status toward the controller
   always_comb begin
      stat.is_free_cmd   = (cmd_ff == ffha_pkg::CMD_FREE);
      stat.zero_size     = (sz_ff == '0);
      stat.free_bad      = (addr_ff == '0) || (addr_ff[ffha_pkg::GRAN_SHIFT-1:0] != '0)
                           || (addr_ff < ffha_pkg::ADDR_W'(ffha_pkg::HDR_SPAN))
                           || (XW'(hp) >= XW'(ARENA)) || !started_ff;
      stat.started       = started_ff;
      stat.past_last     = (pos_ff > last_ff) || (pos_ff >= ARENA);
      stat.fit           = rdata_ff.free && (XW'(rdata_ff.size) >= XW'(sz_ff));
      stat.split         = (XW'(hcur_ff.size) - XW'(sz_ff)) > XW'(HDR);
      stat.at_target     = (XW'(pos_ff) == XW'(hp));
      stat.beyond_target = (XW'(pos_ff) > XW'(hp));
      stat.target_free   = rdata_ff.free;
      stat.pfree         = pfree_ff;
      stat.nfree         = nfree_ff;
      stat.sb_hpos       = (hpos_ff != last_ff) && (np < ARENA);
      stat.sb_np         = (np != last_ff) && (np_succ < ARENA);
   end

   // memory access and register updates per operation
   always_comb begin
      rd_addr    = pos_ff[AW-1:0];
      wr_en      = 1'b0;
      wr_addr    = hpos_ff[AW-1:0];
      wr_data    = hcur_ff;
      pos_in     = pos_ff;
      last_in    = last_ff;
      started_in = started_ff;
      sb_pos_in  = sb_pos_ff;
      sb_val_in  = sb_val_ff;
      case (cmd.op)
         ffha_pkg::OP_INIT: begin
            wr_en      = 1'b1;
            wr_addr    = '0;
            wr_data    = '{size: ARENA - HDR, back: '0, free: 1'b1, has_back: 1'b0};
            started_in = 1'b1;
            last_in    = '0;
            pos_in     = '0;
         end
         ffha_pkg::OP_POS_ZERO: pos_in = '0;
         ffha_pkg::OP_STEP:     pos_in = succ_pos;
         ffha_pkg::OP_A_WR: begin
            wr_en        = 1'b1;
            wr_data.free = 1'b0;
            if (stat.split) begin
               wr_data.size = CW'(sz_ff);
            end
         end
         ffha_pkg::OP_A_SPLIT: begin
            // remainder becomes a free block after the handed-out one
            wr_en     = 1'b1;
            wr_addr   = np_split[AW-1:0];
            wr_data   = '{size: hcur_ff.size - CW'(sz_ff) - HDR, back: hpos_ff[AW-1:0],
                          free: 1'b1, has_back: 1'b1};
            sb_pos_in = np;
            sb_val_in = np_split[AW-1:0];
            if (hpos_ff == last_ff) begin
               last_in = np_split;
            end
         end
         ffha_pkg::OP_RD_NEXT: rd_addr = np[AW-1:0];
         ffha_pkg::OP_RD_PREV: rd_addr = hcur_ff.back;
         ffha_pkg::OP_MERGE: begin
            wr_en = 1'b1;
            if (pfree_ff && nfree_ff) begin
               wr_addr      = pp;
               wr_data      = pb_ff;
               wr_data.size = pb_ff.size + hcur_ff.size + nb_ff.size + HDR + HDR;
               sb_pos_in    = np_succ;
               sb_val_in    = pp;
               if (np == last_ff) begin
                  last_in = CW'(pp);
               end
            end else if (pfree_ff) begin
               wr_addr      = pp;
               wr_data      = pb_ff;
               wr_data.size = pb_ff.size + hcur_ff.size + HDR;
               sb_pos_in    = np;
               sb_val_in    = pp;
               if (hpos_ff == last_ff) begin
                  last_in = CW'(pp);
               end
            end else if (nfree_ff) begin
               wr_data.size = hcur_ff.size + nb_ff.size + HDR;
               wr_data.free = 1'b1;
               sb_pos_in    = np_succ;
               sb_val_in    = hpos_ff[AW-1:0];
               if (np == last_ff) begin
                  last_in = hpos_ff;
               end
            end else begin
               wr_data.free = 1'b1;
            end
         end
         ffha_pkg::OP_RD_SB: rd_addr = sb_pos_ff[AW-1:0];
         ffha_pkg::OP_WR_SB: begin
            wr_en            = 1'b1;
            wr_addr          = sb_pos_ff[AW-1:0];
            wr_data          = rdata_ff;
            wr_data.back     = sb_val_ff;
            wr_data.has_back = 1'b1;
         end
         default: ;
      endcase
   end

   // control state of the arena
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         last_ff    <= '0;
      end else begin
         started_ff <= started_in;
         last_ff    <= last_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      sb_pos_ff <= sb_pos_in;
      sb_val_ff <= sb_val_in;
      case (cmd.op)
         ffha_pkg::OP_LATCH: begin
            cmd_ff  <= req_cmd;
            sz_ff   <= sz_in;
            addr_ff <= req_block_addr;
         end
         ffha_pkg::OP_STEP: begin
            hcur_ff <= rdata_ff;
            hpos_ff <= pos_ff;
         end
         ffha_pkg::OP_CAP_NEXT: begin
            nb_ff    <= rdata_ff;
            nfree_ff <= (hpos_ff != last_ff) && (np < ARENA) && rdata_ff.free;
         end
         ffha_pkg::OP_CAP_PREV: begin
            pb_ff    <= rdata_ff;
            pfree_ff <= hcur_ff.has_back && rdata_ff.free;
         end
         ffha_pkg::OP_LOAD_RSP: begin
            rsp_status_ff <= cmd.code;
            rsp_addr_ff   <= (cmd.code == ffha_pkg::RES_ALLOC) ?
                             ffha_pkg::ADDR_W'(pay_full) : '0;
         end
         default: ;
      endcase
   end

   assign rsp_payload_addr = rsp_addr_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

@@ sv/ffha_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer for allocate and free walks, merges and the response slot.
// ----------------------------------------------------------------------------
module ffha_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ffha_pkg::cmd_type   cmd,
   input  ffha_pkg::stat_type  stat
);

   ffha_pkg::state_type  state_ff, state_in;
   ffha_pkg::result_type code_ff, code_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffha_pkg::ST_IDLE;
         code_ff      <= ffha_pkg::RES_ALLOC;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = ffha_pkg::OP_NONE;
      cmd.code     = code_ff;
      req_ready    = 1'b0;
      case (state_ff)
         ffha_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = ffha_pkg::OP_LATCH;
               state_in = ffha_pkg::ST_DECODE;
            end
         end
         ffha_pkg::ST_DECODE: begin
            if (stat.is_free_cmd) begin
               if (stat.free_bad) begin
                  code_in  = ffha_pkg::RES_IGNORED;
                  state_in = ffha_pkg::ST_DONE;
               end else begin
                  cmd.op   = ffha_pkg::OP_POS_ZERO;
                  state_in = ffha_pkg::ST_F_RD;
               end
            end else if (stat.zero_size) begin
               code_in  = ffha_pkg::RES_ZERO;
               state_in = ffha_pkg::ST_DONE;
            end else if (!stat.started) begin
               state_in = ffha_pkg::ST_INIT;
            end else begin
               cmd.op   = ffha_pkg::OP_POS_ZERO;
               state_in = ffha_pkg::ST_A_RD;
            end
         end
         ffha_pkg::ST_INIT: begin
            cmd.op   = ffha_pkg::OP_INIT;
            state_in = ffha_pkg::ST_A_RD;
         end
         // allocate walk
         ffha_pkg::ST_A_RD: begin
            if (stat.past_last) begin
               code_in  = ffha_pkg::RES_NOSPACE;
               state_in = ffha_pkg::ST_DONE;
            end else begin
               cmd.op   = ffha_pkg::OP_RD_POS;
               state_in = ffha_pkg::ST_A_CHK;
            end
         end
         ffha_pkg::ST_A_CHK: begin
            cmd.op   = ffha_pkg::OP_STEP;
            state_in = stat.fit ? ffha_pkg::ST_A_WR : ffha_pkg::ST_A_RD;
         end
         ffha_pkg::ST_A_WR: begin
            cmd.op  = ffha_pkg::OP_A_WR;
            code_in = ffha_pkg::RES_ALLOC;
            state_in = stat.split ? ffha_pkg::ST_A_SPLIT : ffha_pkg::ST_DONE;
         end
         ffha_pkg::ST_A_SPLIT: begin
            cmd.op   = ffha_pkg::OP_A_SPLIT;
            state_in = stat.sb_hpos ? ffha_pkg::ST_SB_RD : ffha_pkg::ST_DONE;
         end
         // free: find the block, then read neighbors
         ffha_pkg::ST_F_RD: begin
            if (stat.past_last) begin
               code_in  = ffha_pkg::RES_IGNORED;
               state_in = ffha_pkg::ST_DONE;
            end else begin
               cmd.op   = ffha_pkg::OP_RD_POS;
               state_in = ffha_pkg::ST_F_CHK;
            end
         end
         ffha_pkg::ST_F_CHK: begin
            cmd.op = ffha_pkg::OP_STEP;
            if (stat.at_target) begin
               if (stat.target_free) begin
                  code_in  = ffha_pkg::RES_IGNORED;
                  state_in = ffha_pkg::ST_DONE;
               end else begin
                  state_in = ffha_pkg::ST_F_NX;
               end
            end else if (stat.beyond_target) begin
               code_in  = ffha_pkg::RES_IGNORED;
               state_in = ffha_pkg::ST_DONE;
            end else begin
               state_in = ffha_pkg::ST_F_RD;
            end
         end
         ffha_pkg::ST_F_NX: begin
            cmd.op   = ffha_pkg::OP_RD_NEXT;
            state_in = ffha_pkg::ST_F_NXC;
         end
         ffha_pkg::ST_F_NXC: begin
            cmd.op   = ffha_pkg::OP_CAP_NEXT;
            state_in = ffha_pkg::ST_F_PV;
         end
         ffha_pkg::ST_F_PV: begin
            cmd.op   = ffha_pkg::OP_RD_PREV;
            state_in = ffha_pkg::ST_F_PVC;
         end
         ffha_pkg::ST_F_PVC: begin
            cmd.op   = ffha_pkg::OP_CAP_PREV;
            state_in = ffha_pkg::ST_F_MERGE;
         end
         ffha_pkg::ST_F_MERGE: begin
            cmd.op   = ffha_pkg::OP_MERGE;
            code_in  = ffha_pkg::RES_FREED;
            state_in = ffha_pkg::ST_DONE;
            if (stat.nfree && stat.sb_np) begin
               state_in = ffha_pkg::ST_SB_RD;
            end else if (stat.pfree && !stat.nfree && stat.sb_hpos) begin
               state_in = ffha_pkg::ST_SB_RD;
            end
         end
         // back pointer fix-up of the following block
         ffha_pkg::ST_SB_RD: begin
            cmd.op   = ffha_pkg::OP_RD_SB;
            state_in = ffha_pkg::ST_SB_WR;
         end
         ffha_pkg::ST_SB_WR: begin
            cmd.op   = ffha_pkg::OP_WR_SB;
            state_in = ffha_pkg::ST_DONE;
         end
         // hand the result to the response register once it is free
         ffha_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = ffha_pkg::OP_LOAD_RSP;
               rsp_valid_in = 1'b1;
               state_in     = ffha_pkg::ST_IDLE;
            end
         end
         default: state_in = ffha_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ sv/first_fit_heap_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a fixed arena kept as an implicit block list.
//
//   channel   dir  handshake      payload
//   req_if    in   valid/ready    cmd, req_bytes, block_addr
//   rsp_if    out  valid/ready    payload_addr, status
//
// Allocate: each block header visited is read, then checked; the first
// request also sets up the arena, and a split writes the remainder header
// and may fix up a back pointer. Free: walk to the target, read both neighbors, merge, and maybe fix up a back pointer.
// The walk is bound by the single read port of the header memory, which is registered.
// One request at a time; a finished response waits in its output register
// while the next request is taken. Synchronous reset, no clearing pass.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
   parameter int ARENA_GRANULES = 4096
) (
   input logic         clock,
   input logic         reset,
   ffha_req_if.sink    req_if,
   ffha_rsp_if.source  rsp_if
);

   ffha_pkg::cmd_type  cmd;
   ffha_pkg::stat_type stat;

   // sequencer
   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // header memory and datapath
   ffha_dpath #(
      .ARENA_GRANULES (ARENA_GRANULES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_cmd          (req_if.cmd),
      .req_bytes        (req_if.req_bytes),
      .req_block_addr   (req_if.block_addr),
      .rsp_payload_addr (rsp_if.payload_addr),
      .rsp_status       (rsp_if.status)
   );

endmodule

@@ sim/tb_first_fit_heap_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator
// Self-checking testbench of the first-fit heap allocator. A behavioral model
// of the block list predicts each response at request acceptance; responses
// are compared in order. Directed tests cover size edges, fits, bad frees
// and merges; a random phase runs well-formed alloc/free traffic with noise.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NGRAN      = 4096;
   localparam int ARENA_B    = NGRAN * ffha_pkg::GRANULE_BYTES;
   localparam int IDLE_MAX   = 8;
   localparam int WDOG_LIMIT = 100000;
   localparam int RAND_ITEMS = 1930;

   typedef struct packed {
      logic [ffha_pkg::ADDR_W-1:0] addr;
      ffha_pkg::result_type        status;
   } rsp_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ffha_req_if req_bus();
   ffha_rsp_if rsp_bus();

   first_fit_heap_allocator u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus.sink),
      .rsp_if (rsp_bus.source)
   );

   // clock generation
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the block list
   int unsigned blk_size [NGRAN];
   int unsigned blk_back [NGRAN];
   bit          blk_free [NGRAN];
   bit          blk_has_back [NGRAN];
   int unsigned tail_pos;
   bit          heap_started;

   rsp_item_type pending_rsp[$];
   int unsigned  live_addrs[$];
   rsp_item_type last_pred;
   int           mismatches = 0;
   bit           timed_out = 1'b0;
   int           idle_cycles = 0;

   function automatic int unsigned succ_gran(int unsigned pos);
      return pos + (ffha_pkg::HDR_SPAN + blk_size[pos]) / ffha_pkg::GRANULE_BYTES;
   endfunction

   function automatic void relink_back(int unsigned pos, int unsigned back);
      if (pos < NGRAN) begin
         blk_back[pos] = back;
         blk_has_back[pos] = 1'b1;
      end
   endfunction

   function automatic rsp_item_type predict_alloc(int unsigned req);
      rsp_item_type r;
      int unsigned size, pos, steps, bsize, np;
      size = (req + ffha_pkg::GRANULE_BYTES - 1) & ~(ffha_pkg::GRANULE_BYTES - 1);
      r.addr = '0;
      if (size == 0) begin
         r.status = ffha_pkg::RES_ZERO;
         return r;
      end
      if (!heap_started) begin
         blk_size[0] = ARENA_B - ffha_pkg::HDR_SPAN;
         blk_free[0] = 1'b1;
         blk_has_back[0] = 1'b0;
         blk_back[0] = 0;
         tail_pos = 0;
         heap_started = 1'b1;
      end
      pos = 0;
      for (steps = 0; steps < NGRAN && pos <= tail_pos && pos < NGRAN; steps++) begin
         if (blk_free[pos] && blk_size[pos] >= size) begin
            bsize = blk_size[pos];
            // split only when the leftover exceeds one header
            if (bsize - size > ffha_pkg::HDR_SPAN) begin
               blk_size[pos] = size;
               np = succ_gran(pos);
               if (np < NGRAN) begin
                  blk_size[np] = bsize - size - ffha_pkg::HDR_SPAN;
                  blk_free[np] = 1'b1;
                  blk_has_back[np] = 1'b1;
                  blk_back[np] = pos;
                  if (pos == tail_pos) tail_pos = np;
                  else relink_back(succ_gran(np), np);
               end
            end
            blk_free[pos] = 1'b0;
            r.addr = ffha_pkg::ADDR_W'(pos * ffha_pkg::GRANULE_BYTES + ffha_pkg::HDR_SPAN);
            r.status = ffha_pkg::RES_ALLOC;
            return r;
         end
         pos = succ_gran(pos);
      end
      r.status = ffha_pkg::RES_NOSPACE;
      return r;
   endfunction

   function automatic bit is_allocated(int unsigned target);
      int unsigned pos, steps;
      pos = 0;
      for (steps = 0; steps < NGRAN && pos <= tail_pos && pos < NGRAN; steps++) begin
         if (pos == target) return !blk_free[pos];
         if (pos > target) return 1'b0;
         pos = succ_gran(pos);
      end
      return 1'b0;
   endfunction

   function automatic rsp_item_type predict_free(int unsigned addr);
      rsp_item_type r;
      int unsigned hp, np, pp;
      bit pf, nf;
      r.addr = '0;
      r.status = ffha_pkg::RES_IGNORED;
      if (addr == 0 || !heap_started) return r;
      if (addr % ffha_pkg::GRANULE_BYTES != 0 || addr < ffha_pkg::HDR_SPAN) return r;
      hp = (addr - ffha_pkg::HDR_SPAN) / ffha_pkg::GRANULE_BYTES;
      if (hp >= NGRAN || !is_allocated(hp)) return r;
      np = succ_gran(hp);
      pf = blk_has_back[hp] && blk_back[hp] < NGRAN && blk_free[blk_back[hp]];
      nf = hp != tail_pos && np < NGRAN && blk_free[np];
      pp = blk_back[hp];
      // coalesce with free neighbors
      if (pf && nf) begin
         blk_size[pp] = blk_size[pp] + blk_size[hp] + blk_size[np]
                        + 2 * ffha_pkg::HDR_SPAN;
         if (np == tail_pos) tail_pos = pp;
         else relink_back(succ_gran(pp), pp);
      end else if (pf) begin
         blk_size[pp] = blk_size[pp] + blk_size[hp] + ffha_pkg::HDR_SPAN;
         if (hp == tail_pos) tail_pos = pp;
         else relink_back(succ_gran(pp), pp);
      end else if (nf) begin
         blk_size[hp] = blk_size[hp] + blk_size[np] + ffha_pkg::HDR_SPAN;
         blk_free[hp] = 1'b1;
         if (np == tail_pos) tail_pos = hp;
         else relink_back(succ_gran(hp), hp);
      end else begin
         blk_free[hp] = 1'b1;
      end
      r.status = ffha_pkg::RES_FREED;
      return r;
   endfunction

   // drive one request, wait for acceptance, then predict its response
   task automatic send_request(logic cmd, logic [ffha_pkg::BYTES_W-1:0] nbytes,
                               logic [ffha_pkg::ADDR_W-1:0] addr);
      int gap;
      int idx;
      gap = $urandom_range(0, IDLE_MAX);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.cmd        <= cmd;
      req_bus.req_bytes  <= nbytes;
      req_bus.block_addr <= addr;
      req_bus.valid      <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      if (cmd == ffha_pkg::CMD_ALLOC) last_pred = predict_alloc(32'(nbytes));
      else last_pred = predict_free(32'(addr));
      pending_rsp.push_back(last_pred);
      if (cmd == ffha_pkg::CMD_ALLOC && last_pred.status == ffha_pkg::RES_ALLOC)
         live_addrs.push_back(32'(last_pred.addr));
      if (cmd == ffha_pkg::CMD_FREE && last_pred.status == ffha_pkg::RES_FREED) begin
         for (idx = 0; idx < live_addrs.size(); idx++)
            if (live_addrs[idx] == 32'(addr)) begin
               live_addrs.delete(idx);
               break;
            end
      end
   endtask

   task automatic alloc_req(int unsigned nbytes);
      send_request(ffha_pkg::CMD_ALLOC, ffha_pkg::BYTES_W'(nbytes), '0);
   endtask

   task automatic free_req(int unsigned addr);
      send_request(ffha_pkg::CMD_FREE, ffha_pkg::BYTES_W'($urandom()),
                   ffha_pkg::ADDR_W'(addr));
   endtask

   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // frees before the arena exists, and zero or oversized sizes
   task automatic test_unstarted_and_sizes();
      free_req(0);
      free_req(ffha_pkg::HDR_SPAN);
      alloc_req(0);
      alloc_req(16'hFFFF);
      alloc_req(ARENA_B);
   endtask

   // small allocation, too-large request, unsplit fit of the remainder, double free
   task automatic test_fits();
      int unsigned first;
      alloc_req(1);
      first = 32'(last_pred.addr);
      alloc_req(ARENA_B - ffha_pkg::HDR_SPAN);
      alloc_req(ARENA_B - 3 * ffha_pkg::HDR_SPAN - ffha_pkg::GRANULE_BYTES);
      free_req(first);
      free_req(first);
      free_req(live_addrs[0]);
   endtask

   // bad addresses and neighbor merges
   task automatic test_frees_and_merges();
      int unsigned a, b, c, d;
      free_req(15'h7FFF);
      free_req(ffha_pkg::GRANULE_BYTES);
      alloc_req(40);
      a = 32'(last_pred.addr);
      alloc_req(8);
      b = 32'(last_pred.addr);
      alloc_req(24);
      c = 32'(last_pred.addr);
      alloc_req(100);
      d = 32'(last_pred.addr);
      free_req(a + ffha_pkg::GRANULE_BYTES);
      free_req(a);
      free_req(c);
      free_req(b);
      alloc_req(a == 0 ? 8 : 72);
      alloc_req(33);
      free_req(d);
      drain_responses();
   endtask

   // random traffic: mostly well-formed alloc/free, some noise
   task automatic test_random();
      int n, pick;
      for (n = 0; n < RAND_ITEMS; n++) begin
         if (n == RAND_ITEMS / 2) drain_responses();
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            send_request(1'($urandom_range(0, 1)), ffha_pkg::BYTES_W'($urandom()),
                         ffha_pkg::ADDR_W'($urandom()));
         end else if (pick < 8) begin
            alloc_req($urandom_range(1024, 20000));
         end else if (live_addrs.size() > 0 &&
                      (pick < 45 || live_addrs.size() > 80)) begin
            free_req(live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
         end else begin
            alloc_req($urandom_range(0, 3) == 0 ? $urandom_range(0, 1024)
                                                : $urandom_range(1, 96));
         end
      end
   endtask

   // response ready with random stalls
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      forever begin
         stall = $urandom_range(0, IDLE_MAX);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // response checker
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response addr=%0d status=%0d",
                        rsp_bus.payload_addr, rsp_bus.status);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_bus.payload_addr !== want.addr || rsp_bus.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected addr=%0d status=%0d, got addr=%0d status=%0d",
                           want.addr, want.status, rsp_bus.payload_addr, rsp_bus.status);
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("Test completed with failures");
         $finish;
      end
   end

   // test sequence
   initial begin
      int guard;
      req_bus.valid = 1'b0;
      req_bus.cmd = ffha_pkg::CMD_ALLOC;
      req_bus.req_bytes = '0;
      req_bus.block_addr = '0;
      tail_pos = 0;
      heap_started = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unstarted_and_sizes();
      test_fits();
      test_frees_and_merges();
      test_random();
      drain_responses();
      guard = 0;
      while (guard < 200) begin
         @(posedge clock);
         guard++;
      end
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

@@ files.f @@
sv/ffha_pkg.sv
sv/ffha_req_if.sv
sv/ffha_rsp_if.sv
sv/ffha_dpath.sv
sv/ffha_ctrl.sv
sv/first_fit_heap_allocator.sv
sim/tb_first_fit_heap_allocator.sv
